### src/rnv_pkg.sv
// ============================================================================
// rnv_pkg: shared types, codes and tables for the Roman numeral validator
// Symbol indexes, rule pattern table, checker state type and helper functions.
// ============================================================================
`timescale 1ns / 1ps

package rnv_pkg;

    // Symbol indexes: I=0, V=1, X=2, L=3, C=4, D=5, M=6
    localparam logic [3:0] SYM_I     = 4'd0;
    localparam logic [3:0] SYM_V     = 4'd1;
    localparam logic [3:0] SYM_X     = 4'd2;
    localparam logic [3:0] SYM_L     = 4'd3;
    localparam logic [3:0] SYM_C     = 4'd4;
    localparam logic [3:0] SYM_D     = 4'd5;
    localparam logic [3:0] SYM_M     = 4'd6;
    localparam logic [3:0] NO_SYMBOL = 4'd15;
    localparam logic [3:0] GROUP_TOP = 4'd8;

    // ASCII letters of the symbol set, upper case
    localparam logic [7:0] ASCII_I = 8'h49;
    localparam logic [7:0] ASCII_V = 8'h56;
    localparam logic [7:0] ASCII_X = 8'h58;
    localparam logic [7:0] ASCII_L = 8'h4C;
    localparam logic [7:0] ASCII_C = 8'h43;
    localparam logic [7:0] ASCII_D = 8'h44;
    localparam logic [7:0] ASCII_M = 8'h4D;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] ASCII_CASE_OFFSET = 8'd32;

    // Pattern step codes
    localparam logic [1:0] CODE_END  = 2'd0;  // group may end here
    localparam logic [1:0] CODE_ONE  = 2'd1;  // I/X/C/M-type symbol
    localparam logic [1:0] CODE_FIVE = 2'd2;  // V/L/D-type symbol
    localparam logic [1:0] CODE_SUB  = 2'd3;  // subtractive step

    // Reject reasons
    localparam logic [1:0] REASON_OK    = 2'd0;
    localparam logic [1:0] REASON_BAD   = 2'd1;
    localparam logic [1:0] REASON_MIXED = 2'd2;
    localparam logic [1:0] REASON_ORDER = 2'd3;

    localparam int NUM_RULES = 9;

    // Rule shapes: I, II, III, IV, V, VI, VII, VIII, IX
    localparam logic [1:0] PATTERN_CODE [0:NUM_RULES-1][0:7] = '{
        '{CODE_ONE,  CODE_END,  CODE_END, CODE_END, CODE_END, CODE_END, CODE_END, CODE_END},
        '{CODE_ONE,  CODE_ONE,  CODE_END, CODE_END, CODE_END, CODE_END, CODE_END, CODE_END},
        '{CODE_ONE,  CODE_ONE,  CODE_ONE, CODE_END, CODE_END, CODE_END, CODE_END, CODE_END},
        '{CODE_ONE,  CODE_FIVE, CODE_END, CODE_END, CODE_END, CODE_END, CODE_END, CODE_END},
        '{CODE_FIVE, CODE_END,  CODE_END, CODE_END, CODE_END, CODE_END, CODE_END, CODE_END},
        '{CODE_FIVE, CODE_ONE,  CODE_END, CODE_END, CODE_END, CODE_END, CODE_END, CODE_END},
        '{CODE_FIVE, CODE_ONE,  CODE_ONE, CODE_END, CODE_END, CODE_END, CODE_END, CODE_END},
        '{CODE_FIVE, CODE_ONE,  CODE_ONE, CODE_ONE, CODE_END, CODE_END, CODE_END, CODE_END},
        '{CODE_ONE,  CODE_SUB,  CODE_END, CODE_END, CODE_END, CODE_END, CODE_END, CODE_END}
    };

    // Per-word checker state
    typedef struct packed {
        logic [NUM_RULES-1:0] rule_alive;
        logic [2:0]           rule_position;
        logic [3:0]           group_min_symbol;
        logic [3:0]           prior_symbol;
        logic                 skipping_thousands;
        logic                 seen_upper;
        logic                 seen_lower;
        logic                 bad_symbol_seen;
        logic                 order_broken;
    } state_t;

    localparam state_t STATE_RESET = '{
        rule_alive:         '1,
        rule_position:      3'd0,
        group_min_symbol:   GROUP_TOP,
        prior_symbol:       NO_SYMBOL,
        skipping_thousands: 1'b1,
        seen_upper:         1'b0,
        seen_lower:         1'b0,
        bad_symbol_seen:    1'b0,
        order_broken:       1'b0
    };

    // Verdict carried by one result item
    typedef struct packed {
        logic [1:0] reject_reason;
        logic       is_roman;
    } verdict_t;

    // Upper-case ASCII letter to symbol index
    function automatic logic [3:0] symbol_index(input logic [7:0] up);
        logic [3:0] sym;
        begin
            unique case (up)
                ASCII_I: sym = SYM_I;
                ASCII_V: sym = SYM_V;
                ASCII_X: sym = SYM_X;
                ASCII_L: sym = SYM_L;
                ASCII_C: sym = SYM_C;
                ASCII_D: sym = SYM_D;
                ASCII_M: sym = SYM_M;
                default: sym = NO_SYMBOL;
            endcase
            return sym;
        end
    endfunction

    // The current group may close ahead of a smaller symbol
    function automatic logic group_can_close(
        input logic [3:0]           sym,
        input logic [NUM_RULES-1:0] alive,
        input logic [2:0]           pos,
        input logic [3:0]           gmin
    );
        logic any_end;
        begin
            any_end = 1'b0;
            for (int i = 0; i < NUM_RULES; i++) begin
                if (alive[i] && PATTERN_CODE[i][pos] == CODE_END) begin
                    any_end = 1'b1;
                end
            end
            return (sym[3:1] < gmin[3:1]) && any_end;
        end
    endfunction

endpackage

### src/rnv_step.sv
// ============================================================================
// rnv_step: one-byte update of the numeral checker
// Decodes the byte, steps the nine rule patterns and forms the verdict.
// ============================================================================
`timescale 1ns / 1ps

module rnv_step
(
    input  rnv_pkg::state_t   state_cur,
    input  logic [7:0]        char_code,
    output rnv_pkg::state_t   state_nxt,
    output rnv_pkg::verdict_t verdict
);

    logic [7:0]                    up;
    logic [3:0]                    sym;
    logic [3:0]                    psym;
    logic [1:0]                    code;
    logic                          fail;
    logic                          found;
    logic                          closable;
    logic                          fin_close;
    logic [rnv_pkg::NUM_RULES-1:0] alive_w;
    logic [2:0]                    pos_w;
    logic [3:0]                    gmin_w;

    // Case fold and symbol decode
    always_comb
    begin
        up = char_code;
        if (char_code >= rnv_pkg::ASCII_LOWER_A && char_code <= rnv_pkg::ASCII_LOWER_Z)
        begin
            up = char_code - rnv_pkg::ASCII_CASE_OFFSET;
        end
        sym = rnv_pkg::symbol_index(up);
    end

    // Group close test against the previous symbol
    assign closable = rnv_pkg::group_can_close(state_cur.prior_symbol, state_cur.rule_alive,
                                               state_cur.rule_position,
                                               state_cur.group_min_symbol);

    // Rule stepping: group change, subtractive step, pattern filter
    always_comb
    begin
        fail    = 1'b0;
        found   = 1'b0;
        code    = sym[0] ? rnv_pkg::CODE_FIVE : rnv_pkg::CODE_ONE;
        psym    = sym;
        alive_w = state_cur.rule_alive;
        pos_w   = state_cur.rule_position;
        gmin_w  = state_cur.group_min_symbol;
        if (state_cur.prior_symbol != rnv_pkg::NO_SYMBOL)
        begin
            if (sym[3:1] < state_cur.prior_symbol[3:1])
            begin
                if (!closable)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    alive_w = '1;
                    pos_w   = 3'd0;
                    gmin_w  = state_cur.prior_symbol;
                end
            end
            else if (sym[3:1] > state_cur.prior_symbol[3:1])
            begin
                if (sym > state_cur.group_min_symbol)
                begin
                    fail = 1'b1;
                end
                psym = state_cur.prior_symbol;
                code = rnv_pkg::CODE_SUB;
            end
        end
        for (int i = 0; i < rnv_pkg::NUM_RULES; i++)
        begin
            if (alive_w[i])
            begin
                if (rnv_pkg::PATTERN_CODE[i][pos_w] != code)
                begin
                    alive_w[i] = 1'b0;
                end
                else
                begin
                    found = 1'b1;
                end
            end
        end
        if (!found)
        begin
            fail = 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        state_nxt = state_cur;
        if (sym == rnv_pkg::NO_SYMBOL)
        begin
            state_nxt.bad_symbol_seen    = 1'b1;
            state_nxt.skipping_thousands = 1'b0;
        end
        else
        begin
            if (char_code == up)
            begin
                state_nxt.seen_upper = 1'b1;
            end
            else
            begin
                state_nxt.seen_lower = 1'b1;
            end
            // leading M symbols are skipped
            if (!(state_cur.skipping_thousands && sym == rnv_pkg::SYM_M))
            begin
                state_nxt.skipping_thousands = 1'b0;
                if (!state_cur.order_broken)
                begin
                    if (fail)
                    begin
                        state_nxt.order_broken = 1'b1;
                    end
                    else
                    begin
                        state_nxt.rule_alive       = alive_w;
                        state_nxt.rule_position    = pos_w + 3'd1;
                        state_nxt.group_min_symbol = gmin_w;
                        state_nxt.prior_symbol     = psym;
                    end
                end
            end
        end
    end

    // Word end: the last group must be able to close
    assign fin_close = rnv_pkg::group_can_close(rnv_pkg::SYM_I, state_nxt.rule_alive,
                                                state_nxt.rule_position,
                                                state_nxt.group_min_symbol);

    // Verdict, by reason priority
    always_comb
    begin
        verdict.is_roman      = 1'b0;
        verdict.reject_reason = rnv_pkg::REASON_ORDER;
        if (state_nxt.bad_symbol_seen)
        begin
            verdict.reject_reason = rnv_pkg::REASON_BAD;
        end
        else if (state_nxt.seen_upper && state_nxt.seen_lower)
        begin
            verdict.reject_reason = rnv_pkg::REASON_MIXED;
        end
        else if (state_nxt.order_broken)
        begin
            verdict.reject_reason = rnv_pkg::REASON_ORDER;
        end
        else if (state_nxt.skipping_thousands || fin_close)
        begin
            verdict.is_roman      = 1'b1;
            verdict.reject_reason = rnv_pkg::REASON_OK;
        end
    end

endmodule

### src/roman_numeral_validator.sv
// ============================================================================
// roman_numeral_validator: streaming Roman numeral word checker
// Checks a word given one ASCII byte per item and reports a verdict per word.
// ============================================================================
// Takes one byte per cycle on s_axis (tlast marks the word's final byte) and
// gives one verdict item on m_axis per word, after its last byte has passed the
// input register. Bytes pass an input register, then one step of the rule checker
// updates the word state; the verdict lands in an output register, so the
// input keeps flowing while a verdict waits. Sustained rate is one item per
// cycle, limited only by m_axis backpressure on last bytes. Words of any case
// are accepted, but all bytes must be in one case.
`timescale 1ns / 1ps

module roman_numeral_validator
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tlast,   // last_char

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] is_roman, [2:1] reject_reason, [7:3] zero
);

    logic                in_valid_reg;
    logic [7:0]          in_char_reg;
    logic                in_last_reg;
    rnv_pkg::state_t     state_reg;
    rnv_pkg::state_t     state_next;
    rnv_pkg::state_t     step_state;
    rnv_pkg::verdict_t   step_verdict;
    logic                out_valid_reg;
    rnv_pkg::verdict_t   out_verdict_reg;
    logic                out_free;
    logic                proc;

    // Handshake: a byte moves on unless it is a last byte blocked at the output
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || proc;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Checker step
    rnv_step u_step
    (
        .state_cur (state_reg),
        .char_code (in_char_reg),
        .state_nxt (step_state),
        .verdict   (step_verdict)
    );

    // Word state, cleared after each last byte
    always_comb
    begin
        state_next = state_reg;
        if (proc)
        begin
            state_next = in_last_reg ? rnv_pkg::STATE_RESET : step_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rnv_pkg::STATE_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= proc && in_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && in_last_reg)
        begin
            out_verdict_reg <= step_verdict;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_verdict_reg};

endmodule
